// ===== hw/rtl/lphp_pkg.sv =====
// Shared types, constants and bit helpers for the lossless pixel Huffman packer.
// Used by every module under hw/rtl; depends on nothing else.
package lphp_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned CODE_W   = 9;
	localparam int unsigned PEND_W   = 7;
	localparam int unsigned PCNT_W   = 3;
	localparam int unsigned WORD_W   = 40;
	localparam int unsigned PIX_W    = 33;
	localparam int unsigned NBYTE_W  = 3;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	localparam logic [CHAN_W-1:0] GREEN_SPLIT = 8'd232;

	localparam logic [PEND_W-1:0] START_BITS_RST  = 7'd0;
	localparam logic [PCNT_W-1:0] START_COUNT_RST = 3'd3;

	// Register index, taken from paddr[2].
	localparam logic REG_START_BITS  = 1'b0;
	localparam logic REG_START_COUNT = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              long_code;
	} lane_code_t;

	typedef struct packed {
		logic [PEND_W-1:0] bits;
		logic [PCNT_W-1:0] count;
	} start_cfg_t;

	typedef struct packed {
		logic       en;
		start_cfg_t cfg;
	} cfg_load_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [NBYTE_W-1:0] nbytes;
		logic               last;
	} job_t;

	function automatic logic [CHAN_W-1:0] rev8(input logic [CHAN_W-1:0] v);
		logic [CHAN_W-1:0] r;
		for (int i = 0; i < CHAN_W; i++) begin
			r[i] = v[CHAN_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [CODE_W-1:0] rev9(input logic [CODE_W-1:0] v);
		logic [CODE_W-1:0] r;
		for (int i = 0; i < CODE_W; i++) begin
			r[i] = v[CODE_W-1-i];
		end
		return r;
	endfunction

	// Keeps only the lowest count bits.
	function automatic logic [PEND_W-1:0] mask_bits(input logic [PEND_W-1:0] bits,
			input logic [PCNT_W-1:0] count);
		logic [PEND_W-1:0] m;
		for (int i = 0; i < PEND_W; i++) begin
			m[i] = (PCNT_W'(i) < count);
		end
		return bits & m;
	endfunction

endpackage

// ===== hw/rtl/lphp_lane.sv =====
// One coding lane: turns a channel value into its fixed canonical code.
// Depends on lphp_pkg.
module lphp_lane (
	input  logic [lphp_pkg::CHAN_W-1:0] value,
	input  logic                        wide_en,
	output lphp_pkg::lane_code_t        code
);

	logic                        use_long;
	logic [lphp_pkg::CODE_W-1:0] sum;

	always_comb begin
		use_long = wide_en && (value >= lphp_pkg::GREEN_SPLIT);
		sum      = lphp_pkg::CODE_W'(value) + lphp_pkg::CODE_W'(lphp_pkg::GREEN_SPLIT);
		code.long_code = use_long;
		if (use_long) begin
			code.code = lphp_pkg::rev9(sum);
		end else begin
			code.code = lphp_pkg::CODE_W'(lphp_pkg::rev8(value));
		end
	end

endmodule

// ===== hw/rtl/lphp_merge.sv =====
// Merging stage: joins the four lane codes behind the pending bits, counts the
// bytes of the pixel and keeps the pending state. Depends on lphp_pkg.
module lphp_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 last_pixel,
	input  lphp_pkg::lane_code_t green_code,
	input  lphp_pkg::lane_code_t red_code,
	input  lphp_pkg::lane_code_t blue_code,
	input  lphp_pkg::lane_code_t alpha_code,
	input  lphp_pkg::start_cfg_t start_cfg,
	input  lphp_pkg::cfg_load_t  cfg_load,
	output lphp_pkg::job_t       job
);

	logic [lphp_pkg::PEND_W-1:0]  pend_bits_q;
	logic [lphp_pkg::PCNT_W-1:0]  pend_count_q;
	logic [23:0]                  tail;
	logic [lphp_pkg::PIX_W-1:0]   pix;
	logic [5:0]                   total;
	logic [lphp_pkg::NBYTE_W-1:0] nfull;
	logic [lphp_pkg::PCNT_W-1:0]  rem;
	logic [lphp_pkg::PEND_W-1:0]  next_bits;

	always_comb begin
		tail  = {alpha_code.code[7:0], blue_code.code[7:0], red_code.code[7:0]};
		pix   = (lphp_pkg::PIX_W'(tail) << (green_code.long_code ? 4'd9 : 4'd8))
			| lphp_pkg::PIX_W'(green_code.code);
		total = 6'(pend_count_q) + (green_code.long_code ? 6'd33 : 6'd32);
		nfull = total[5:3];
		rem   = total[2:0];
		job.word   = lphp_pkg::WORD_W'(pend_bits_q)
			| (lphp_pkg::WORD_W'(pix) << pend_count_q);
		job.nbytes = nfull + lphp_pkg::NBYTE_W'(last_pixel && (rem != '0));
		job.last   = last_pixel;
		// With five full bytes the pixel used every bit and nothing stays pending.
		next_bits  = (nfull == 3'd4) ? job.word[38:32] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q  <= lphp_pkg::START_BITS_RST;
			pend_count_q <= lphp_pkg::START_COUNT_RST;
		end else if (cfg_load.en) begin
			pend_bits_q  <= lphp_pkg::mask_bits(cfg_load.cfg.bits, cfg_load.cfg.count);
			pend_count_q <= cfg_load.cfg.count;
		end else if (accept) begin
			if (last_pixel) begin
				pend_bits_q  <= lphp_pkg::mask_bits(start_cfg.bits, start_cfg.count);
				pend_count_q <= start_cfg.count;
			end else begin
				pend_bits_q  <= next_bits;
				pend_count_q <= rem;
			end
		end
	end

endmodule

// ===== hw/rtl/lphp_serializer.sv =====
// Byte serialiser: a holding slot, the pixel word being emitted and the output
// register that presents one byte per item. Depends on lphp_pkg.
module lphp_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  lphp_pkg::job_t       job,
	output logic                 slot_full,
	output logic                 byte_valid,
	input  logic                 byte_stall,
	output logic [7:0]           out_byte,
	output logic                 run_end,
	output logic                 stream_end
);

	logic                         slot_valid_q;
	lphp_pkg::job_t               slot_q;
	logic [lphp_pkg::WORD_W-1:0]  word_q;
	logic [lphp_pkg::NBYTE_W-1:0] left_q;
	logic                         last_q;
	logic                         byte_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         run_end_q;
	logic                         stream_end_q;
	logic                         out_free;
	logic                         emit;
	logic                         move;

	always_comb begin
		out_free = !byte_valid_q || !byte_stall;
		emit     = out_free && (left_q != '0);
		move     = slot_valid_q && ((left_q == '0) || (emit && (left_q == 3'd1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
			left_q       <= '0;
			byte_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				slot_valid_q <= 1'b1;
			end else if (move) begin
				slot_valid_q <= 1'b0;
			end
			if (move) begin
				left_q <= slot_q.nbytes;
			end else if (emit) begin
				left_q <= left_q - 3'd1;
			end
			if (emit) begin
				byte_valid_q <= 1'b1;
			end else if (out_free) begin
				byte_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= job;
		end
		if (move) begin
			word_q <= slot_q.word;
			last_q <= slot_q.last;
		end else if (emit) begin
			word_q <= word_q >> 8;
		end
		if (emit) begin
			out_byte_q   <= word_q[7:0];
			run_end_q    <= (left_q == 3'd1);
			stream_end_q <= (left_q == 3'd1) && last_q;
		end
	end

	assign slot_full  = slot_valid_q;
	assign byte_valid = byte_valid_q;
	assign out_byte   = out_byte_q;
	assign run_end    = run_end_q;
	assign stream_end = stream_end_q;

endmodule

// ===== hw/rtl/lossless_pixel_huffman_packer.sv =====
// Lossless pixel Huffman packer: four coding lanes, a merging stage and a byte serialiser.
// Path: with the serialiser idle, an accepted pixel goes from the holding slot to the word
// register, and its first byte is then registered in the output register and presented.
// Throughput: one byte per cycle while byte_stall is low; a pixel gives 4 or 5 bytes. The
// one-byte output register sets this, and a new pixel is taken whenever the slot is free.
// Reset: start_bits clears, start_count becomes 3, and three zero bits are pending.
// Depends on lphp_pkg, lphp_lane, lphp_merge and lphp_serializer.
module lossless_pixel_huffman_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic [lphp_pkg::CHAN_W-1:0]   red,
	input  logic [lphp_pkg::CHAN_W-1:0]   green,
	input  logic [lphp_pkg::CHAN_W-1:0]   blue,
	input  logic [lphp_pkg::CHAN_W-1:0]   alpha,
	input  logic                          last_pixel,
	output logic                          byte_valid,
	input  logic                          byte_stall,
	output logic [7:0]                    out_byte,
	output logic                          run_end,
	output logic                          stream_end,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lphp_pkg::APB_AW-1:0]   paddr,
	input  logic [lphp_pkg::APB_DW-1:0]   pwdata,
	output logic [lphp_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	lphp_pkg::start_cfg_t start_cfg_q;
	lphp_pkg::cfg_load_t  cfg_load;
	lphp_pkg::lane_code_t green_code;
	lphp_pkg::lane_code_t red_code;
	lphp_pkg::lane_code_t blue_code;
	lphp_pkg::lane_code_t alpha_code;
	lphp_pkg::job_t       job;
	logic                 slot_full;
	logic                 accept;
	logic                 wr_en;

	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite;
	assign pix_stall = slot_full;
	assign accept    = pix_valid && !slot_full;

	// A write reloads the pending state with the register values it leaves behind.
	always_comb begin
		cfg_load.en  = wr_en;
		cfg_load.cfg = start_cfg_q;
		if (wr_en) begin
			unique case (paddr[2])
				lphp_pkg::REG_START_BITS:  cfg_load.cfg.bits  = pwdata[lphp_pkg::PEND_W-1:0];
				lphp_pkg::REG_START_COUNT: cfg_load.cfg.count = pwdata[lphp_pkg::PCNT_W-1:0];
				default: cfg_load.cfg = start_cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_cfg_q.bits  <= lphp_pkg::START_BITS_RST;
			start_cfg_q.count <= lphp_pkg::START_COUNT_RST;
		end else if (wr_en) begin
			start_cfg_q <= cfg_load.cfg;
		end
	end

	always_comb begin
		unique case (paddr[2])
			lphp_pkg::REG_START_BITS:  prdata = lphp_pkg::APB_DW'(start_cfg_q.bits);
			lphp_pkg::REG_START_COUNT: prdata = lphp_pkg::APB_DW'(start_cfg_q.count);
			default: prdata = '0;
		endcase
	end

	lphp_lane u_lane_green (.value(green), .wide_en(1'b1), .code(green_code));
	lphp_lane u_lane_red   (.value(red),   .wide_en(1'b0), .code(red_code));
	lphp_lane u_lane_blue  (.value(blue),  .wide_en(1'b0), .code(blue_code));
	lphp_lane u_lane_alpha (.value(alpha), .wide_en(1'b0), .code(alpha_code));

	lphp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.last_pixel (last_pixel),
		.green_code (green_code),
		.red_code   (red_code),
		.blue_code  (blue_code),
		.alpha_code (alpha_code),
		.start_cfg  (start_cfg_q),
		.cfg_load   (cfg_load),
		.job        (job)
	);

	lphp_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.job        (job),
		.slot_full  (slot_full),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

endmodule
